### rtl/gfc_pkg.sv
`default_nettype none
package gfc_pkg;

  localparam int DefMaxWidth = 256;
  localparam int DefMaxHeight = 256;
  localparam int DefPaletteDepth = 256;

  localparam logic [1:0] CMD_HEADER  = 2'd0;
  localparam logic [1:0] CMD_PALETTE = 2'd1;
  localparam logic [1:0] CMD_PIXEL   = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  localparam logic [2:0] DISP_BACKGROUND = 3'd2;
  localparam logic [2:0] DISP_PREVIOUS   = 3'd3;

  localparam logic [0:0] REG_WIDTH  = 1'd0;
  localparam logic [0:0] REG_HEIGHT = 1'd1;

  localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

  // Unpacked input item.
  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [15:0]        frame_width;
    logic [15:0]        frame_height;
    logic [2:0]         disposal;
    logic               has_transparency;
    logic [7:0]         transparent_index;
    logic [8:0]         color_count;
    logic [7:0]         color_index;
    logic [23:0]        color_rgb;
  } item_t;

  // Request from the sequencer to the canvas memory unit.
  typedef struct packed {
    logic        wr;
    logic        rd;
    logic        snap_wr;
    logic        snap_rd;
    logic        clr;
  } mem_op_t;

endpackage
`default_nettype wire

### rtl/gfc_canvas_mem.sv
`default_nettype none
module gfc_canvas_mem #(
  parameter int AW = 16
) (
  input  wire logic          clk,
  input  wire gfc_pkg::mem_op_t op,
  input  wire logic [AW-1:0] addr,
  input  wire logic [31:0]   wdata,
  output logic [31:0]        canvas_q,
  output logic [31:0]        snap_q
);
  import gfc_pkg::*;

  logic [31:0] canvas_mem [2**AW];
  logic [31:0] snap_mem [2**AW];

  // Canvas memory: at most one write and one read a cycle.
  always_ff @(posedge clk) begin
    if (op.wr) begin
      canvas_mem[addr] <= op.clr ? 32'd0 : wdata;
    end
    if (op.rd) begin
      canvas_q <= canvas_mem[addr];
    end
  end

  // Snapshot memory: at most one write and one read a cycle.
  always_ff @(posedge clk) begin
    if (op.snap_wr) begin
      snap_mem[addr] <= wdata;
    end
    if (op.snap_rd) begin
      snap_q <= snap_mem[addr];
    end
  end

endmodule
`default_nettype wire

### rtl/gif_frame_compositor.sv
`default_nettype none
// Animated GIF frame compositor on an ARGB canvas.
// Items enter on s_axis (tdata packs the command fields), configuration
// registers are written on cfg_we/cfg_index/cfg_data; the user must do so only
// while the block is idle, which the block does not enforce. Only canvas reads
// (command 3) return an item on m_axis. After reset a clearing pass writes
// every canvas word to zero, during which s_axis_tready is low. A pixel is
// looked up in the palette on accept, then clip-checked and written to the
// canvas, or dropped on accept when no frame is active or the frame rectangle
// is already covered; a read goes through a canvas read and then the output
// register. A frame header first sweeps the old rectangle for disposal, when
// the previous disposal is background or previous, with a read and a write
// step per pixel, and then copies the whole canvas into the snapshot with a
// read and a write step per word. Each step is serialised because the canvas
// and snapshot memories share one address driven by a single sequencer.
// A read result waits in the output register while m_axis_tready is low;
// the next item is accepted only once that register is free.
module gif_frame_compositor
  import gfc_pkg::*;
#(
  parameter int MAX_WIDTH = DefMaxWidth,
  parameter int MAX_HEIGHT = DefMaxHeight,
  parameter int PALETTE_DEPTH = DefPaletteDepth
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // command[1:0], left[17:2], top[33:18], frame_width[49:34],
  // frame_height[65:50], disposal[68:66], has_transparency[69],
  // transparent_index[77:70], color_count[86:78], color_index[94:87],
  // color_rgb[118:95], zero fill to 120
  input  wire logic [119:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // canvas_pixel[31:0]
  output logic [31:0]       m_axis_tdata,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [8:0]   cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int PW = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] PAL_DEPTH9 = 9'(PALETTE_DEPTH);
  localparam logic [12:0] MAXW13 = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH13 = 13'(MAX_HEIGHT);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_DISP_RD = 10'b0000000100,
    S_DISP_WR = 10'b0000001000,
    S_SNAP_RD = 10'b0000010000,
    S_SNAP_WR = 10'b0000100000,
    S_PAL     = 10'b0001000000,
    S_PIX     = 10'b0010000000,
    S_READ    = 10'b0100000000,
    S_READ2   = 10'b1000000000
  } state_t;

  state_t state;
  item_t item;
  item_t in_item;

  logic [8:0] canvas_width, canvas_height;
  logic [12:0] eff_w, eff_h;

  logic [23:0] palette [PALETTE_DEPTH];
  logic [23:0] pal_q;

  logic [2:0] prev_disposal;
  logic signed [15:0] prev_x, prev_y, cur_x, cur_y;
  logic [15:0] prev_w, prev_h, cur_w, cur_h;
  logic cur_has_tr;
  logic [7:0] cur_tr_idx;
  logic [8:0] cur_count;
  logic [15:0] pixel_col, pixel_row;

  // Sweep counters shared by clearing, disposal and snapshot.
  logic [YW:0] sy;
  logic [XW:0] sx;
  logic [YW:0] y_end;
  logic [XW:0] x_start, x_end;
  logic restore;
  logic skip_pixel;
  logic [AW-1:0] pix_addr;

  mem_op_t op;
  logic [AW-1:0] addr;
  logic [31:0] wdata;
  logic [31:0] canvas_q, snap_q;
  logic out_zero;

  // Unpack tdata, command in the lowest bits.
  assign in_item = {s_axis_tdata[1:0], s_axis_tdata[17:2], s_axis_tdata[33:18],
                    s_axis_tdata[49:34], s_axis_tdata[65:50], s_axis_tdata[68:66],
                    s_axis_tdata[69], s_axis_tdata[77:70], s_axis_tdata[86:78],
                    s_axis_tdata[94:87], s_axis_tdata[118:95]};

  gfc_canvas_mem #(.AW(AW)) u_mem (
    .clk(clk), .op(op), .addr(addr), .wdata(wdata),
    .canvas_q(canvas_q), .snap_q(snap_q)
  );

  assign eff_w = (13'(canvas_width) > MAXW13) ? MAXW13 : 13'(canvas_width);
  assign eff_h = (13'(canvas_height) > MAXH13) ? MAXH13 : 13'(canvas_height);
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  // Clipped disposal rectangle bounds, computed on the header item.
  logic signed [17:0] dx1, dy1;
  logic [XW:0] dx0c, dx1c;
  logic [YW:0] dy0c, dy1c;
  always_comb begin
    dx1 = 18'(prev_x) + 18'(prev_w);
    dy1 = 18'(prev_y) + 18'(prev_h);
    dx0c = prev_x[15] ? '0 :
           ((17'(prev_x) > 17'(eff_w)) ? (XW+1)'(eff_w) : (XW+1)'(prev_x));
    dy0c = prev_y[15] ? '0 :
           ((17'(prev_y) > 17'(eff_h)) ? (YW+1)'(eff_h) : (YW+1)'(prev_y));
    dx1c = dx1[17] ? '0 :
           ((dx1 > 18'(eff_w)) ? (XW+1)'(eff_w) : (XW+1)'(dx1));
    dy1c = dy1[17] ? '0 :
           ((dy1 > 18'(eff_h)) ? (YW+1)'(eff_h) : (YW+1)'(dy1));
  end

  // Pixel position and skip test.
  logic signed [17:0] cx, cy;
  always_comb begin
    cx = 18'(cur_x) + 18'(pixel_col);
    cy = 18'(cur_y) + 18'(pixel_row);
    skip_pixel = cx[17] || (cx >= 18'(eff_w)) || cy[17] || (cy >= 18'(eff_h))
                 || (cur_has_tr && (item.color_index == cur_tr_idx))
                 || (9'(item.color_index) >= cur_count)
                 || (9'(item.color_index) >= PAL_DEPTH9);
    pix_addr = {cy[YW-1:0], cx[XW-1:0]};
  end

  // Memory requests issued by the sequencer.
  always_comb begin
    op = '0;
    addr = {sy[YW-1:0], sx[XW-1:0]};
    wdata = 32'd0;
    case (state)
      S_CLEAR: begin
        op.wr = 1'b1;
        op.clr = 1'b1;
      end
      S_DISP_RD: begin
        op.snap_rd = 1'b1;
      end
      S_DISP_WR: begin
        op.wr = 1'b1;
        op.clr = !restore;
        wdata = snap_q;
      end
      S_SNAP_RD: begin
        op.rd = 1'b1;
      end
      S_SNAP_WR: begin
        op.snap_wr = 1'b1;
        wdata = canvas_q;
      end
      S_PIX: begin
        op.wr = !skip_pixel;
        addr = pix_addr;
        wdata = {OPAQUE_ALPHA, pal_q};
      end
      S_READ: begin
        op.rd = 1'b1;
        addr = {item.top[YW-1:0], item.left[XW-1:0]};
      end
      default: begin
      end
    endcase
  end

  // Palette memory with registered read.
  always_ff @(posedge clk) begin
    if (state == S_PAL && 9'(item.color_index) < PAL_DEPTH9) begin
      palette[item.color_index[PW-1:0]] <= item.color_rgb;
    end
    if (state == S_IDLE) begin
      pal_q <= palette[in_item.color_index[PW-1:0]];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sx <= '0;
      sy <= '0;
      canvas_width <= 9'd256;
      canvas_height <= 9'd256;
      prev_disposal <= '0;
      prev_x <= '0; prev_y <= '0; prev_w <= '0; prev_h <= '0;
      cur_x <= '0; cur_y <= '0; cur_w <= '0; cur_h <= '0;
      cur_has_tr <= 1'b0;
      cur_tr_idx <= '0;
      cur_count <= '0;
      pixel_col <= '0;
      pixel_row <= '0;
      m_axis_tvalid <= 1'b0;
      restore <= 1'b0;
      x_start <= '0; x_end <= '0; y_end <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) canvas_width <= cfg_data;
        else canvas_height <= cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (sx == (XW+1)'(MAX_WIDTH - 1)) begin
            sx <= '0;
            if (sy == (YW+1)'(MAX_HEIGHT - 1)) begin
              sy <= '0;
              state <= S_IDLE;
            end else begin
              sy <= sy + 1'b1;
            end
          end else begin
            sx <= sx + 1'b1;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            item <= in_item;
            case (in_item.command)
              CMD_HEADER: begin
                restore <= (prev_disposal == DISP_PREVIOUS);
                x_start <= dx0c;
                x_end <= dx1c;
                y_end <= dy1c;
                if ((prev_disposal == DISP_BACKGROUND ||
                     prev_disposal == DISP_PREVIOUS) &&
                    dx0c < dx1c && dy0c < dy1c) begin
                  sx <= dx0c;
                  sy <= dy0c;
                  state <= S_DISP_RD;
                end else begin
                  sx <= '0;
                  sy <= '0;
                  state <= S_SNAP_RD;
                end
              end
              CMD_PALETTE: state <= S_PAL;
              CMD_PIXEL: begin
                if (cur_count == 9'd0 || cur_w == 16'd0 || pixel_row >= cur_h) begin
                  state <= S_IDLE;
                end else begin
                  state <= S_PIX;
                end
              end
              CMD_READ: state <= S_READ;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DISP_RD: state <= S_DISP_WR;
        S_DISP_WR: begin
          if (sx + 1'b1 >= x_end) begin
            if (sy + 1'b1 >= y_end) begin
              sx <= '0;
              sy <= '0;
              state <= S_SNAP_RD;
            end else begin
              sx <= x_start;
              sy <= sy + 1'b1;
              state <= S_DISP_RD;
            end
          end else begin
            sx <= sx + 1'b1;
            state <= S_DISP_RD;
          end
        end
        S_SNAP_RD: state <= S_SNAP_WR;
        S_SNAP_WR: begin
          if (sx == (XW+1)'(MAX_WIDTH - 1)) begin
            sx <= '0;
            if (sy == (YW+1)'(MAX_HEIGHT - 1)) begin
              sy <= '0;
              state <= S_IDLE;
              pixel_col <= '0;
              pixel_row <= '0;
              if (item.color_count == 9'd0) begin
                cur_count <= '0;
                cur_has_tr <= 1'b0;
                cur_tr_idx <= '0;
              end else begin
                cur_x <= item.left;
                cur_y <= item.top;
                cur_w <= item.frame_width;
                cur_h <= item.frame_height;
                cur_has_tr <= item.has_transparency;
                cur_tr_idx <= item.transparent_index;
                cur_count <= item.color_count;
                prev_x <= item.left;
                prev_y <= item.top;
                prev_w <= item.frame_width;
                prev_h <= item.frame_height;
                prev_disposal <= item.disposal;
              end
            end else begin
              sy <= sy + 1'b1;
              state <= S_SNAP_RD;
            end
          end else begin
            sx <= sx + 1'b1;
            state <= S_SNAP_RD;
          end
        end
        S_PAL: state <= S_IDLE;
        S_PIX: begin
          state <= S_IDLE;
          if (pixel_col + 16'd1 >= cur_w) begin
            pixel_col <= '0;
            pixel_row <= pixel_row + 16'd1;
          end else begin
            pixel_col <= pixel_col + 16'd1;
          end
        end
        S_READ: state <= S_READ2;
        S_READ2: begin
          state <= S_IDLE;
          m_axis_tvalid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register; out-of-canvas reads give zero.
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      out_zero <= item.left[15] || (17'(item.left) >= 17'(eff_w)) ||
                  item.top[15] || (17'(item.top) >= 17'(eff_h));
    end
    if (state == S_READ2) begin
      m_axis_tdata <= out_zero ? 32'd0 : canvas_q;
    end
  end

  // The input is never taken while a result waits.
  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted while a result waits");

  // A read result becomes valid once the read has passed S_READ and S_READ2.
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> ##1 m_axis_tvalid)
    else $error("read result missing");

  // The snapshot sweep never starts outside a header.
  a_snap_header: assert property (@(posedge clk) disable iff (rst)
    (state == S_SNAP_RD) |-> (item.command == CMD_HEADER))
    else $error("snapshot sweep without header");

endmodule
`default_nettype wire
